/* rtl/pfta_pkg.sv */
// Shared types, constants and width helpers for the perspective floor texel
// address pipeline. No dependencies.

package pfta_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int STEP_W    = 32;
  localparam int TRIG_W    = 16;
  localparam int TRIG_FRAC = 14;
  localparam int DIM_W     = 13;
  localparam int TEX_W     = 12;
  localparam int INDEX_W   = 24;
  localparam int DIGIT     = 4;

  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 4;

  localparam logic signed [TRIG_W-1:0] TRIG_POS = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] TRIG_NEG = -16'sd16384;
  localparam logic [DIM_W-1:0]         TEX_MAX  = 13'd4096;
  localparam logic [DIM_W-1:0]         TEX_MIN  = 13'd1;

  localparam logic [TRIG_W-1:0] COS_RESET     = 16'd16384;
  localparam logic [STEP_W-1:0] DEPTH_RESET   = 32'd65536;
  localparam logic [STEP_W-1:0] LATERAL_RESET = 32'd256;
  localparam logic [DIM_W-1:0]  DIM_RESET     = 13'd256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_X       = 4'd0,
    REG_ORIGIN_Y       = 4'd1,
    REG_COS_ANGLE      = 4'd2,
    REG_SIN_ANGLE      = 4'd3,
    REG_DEPTH_STEP     = 4'd4,
    REG_LATERAL_STEP   = 4'd5,
    REG_TEXTURE_WIDTH  = 4'd6,
    REG_TEXTURE_HEIGHT = 4'd7
  } reg_index_t;

  typedef struct packed {
    logic adv;
    logic valid;
  } pipe_ctrl_t;

  function automatic int lat_width(int coord_bits);
    return coord_bits + STEP_W + 1;
  endfunction

  function automatic int sum_width(int coord_bits);
    return lat_width(coord_bits) + TRIG_W + 2;
  endfunction

  function automatic int mag_width(int coord_bits, int frac_bits);
    return sum_width(coord_bits) - 1 - (frac_bits + TRIG_FRAC);
  endfunction

endpackage

/* rtl/pfta_if.sv */
// Valid/ready channel interfaces for pixel beats in and texel beats out.
// Depends on pfta_pkg.

interface pfta_in_if #(
  parameter int COORD_BITS = pfta_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] column_offset;
  logic signed [COORD_BITS-1:0] screen_row;

  modport source (output valid, output column_offset, output screen_row, input ready);
  modport sink (input valid, input column_offset, input screen_row, output ready);
endinterface

interface pfta_out_if;
  logic                          valid;
  logic                          ready;
  logic [pfta_pkg::TEX_W-1:0]    texel_x;
  logic [pfta_pkg::TEX_W-1:0]    texel_y;
  logic [pfta_pkg::INDEX_W-1:0]  texel_index;

  modport source (output valid, output texel_x, output texel_y, output texel_index,
                  input ready);
  modport sink (input valid, input texel_x, input texel_y, input texel_index,
                output ready);
endinterface

/* rtl/pfta_rotate.sv */
// Four-stage front end: step products, rotation products, origin sums, and
// truncation toward zero split into sign and magnitude. Depends on pfta_pkg.

module pfta_rotate #(
  parameter int COORD_BITS = pfta_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pfta_pkg::FRAC_BITS_DEF,
  localparam int MAG_W     = pfta_pkg::mag_width(COORD_BITS, FRAC_BITS)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pfta_pkg::pipe_ctrl_t                  ctrl,
  input  logic signed [COORD_BITS-1:0]          column_offset,
  input  logic signed [COORD_BITS-1:0]          screen_row,
  input  logic signed [pfta_pkg::STEP_W-1:0]    origin_x,
  input  logic signed [pfta_pkg::STEP_W-1:0]    origin_y,
  input  logic signed [pfta_pkg::TRIG_W-1:0]    cos_angle,
  input  logic signed [pfta_pkg::TRIG_W-1:0]    sin_angle,
  input  logic [pfta_pkg::STEP_W-1:0]           depth_step,
  input  logic [pfta_pkg::STEP_W-1:0]           lateral_step,
  output logic                                  valid,
  output logic                                  x_neg,
  output logic [MAG_W-1:0]                      x_mag,
  output logic                                  y_neg,
  output logic [MAG_W-1:0]                      y_mag
);

  localparam int LAT_W  = pfta_pkg::lat_width(COORD_BITS);
  localparam int PROD_W = LAT_W + pfta_pkg::TRIG_W;
  localparam int SUM_W  = pfta_pkg::sum_width(COORD_BITS);
  localparam int SHIFT  = FRAC_BITS + pfta_pkg::TRIG_FRAC;

  logic signed [LAT_W-1:0]  off_ext;
  logic signed [LAT_W-1:0]  row_ext;
  logic signed [LAT_W-1:0]  lstep_ext;
  logic signed [LAT_W-1:0]  dstep_ext;
  logic signed [LAT_W-1:0]  lat;
  logic signed [LAT_W-1:0]  dep;
  logic signed [PROD_W-1:0] lat_ext;
  logic signed [PROD_W-1:0] dep_ext;
  logic signed [PROD_W-1:0] cos_ext;
  logic signed [PROD_W-1:0] sin_ext;
  logic signed [PROD_W-1:0] p_lc;
  logic signed [PROD_W-1:0] p_ls;
  logic signed [PROD_W-1:0] p_dc;
  logic signed [PROD_W-1:0] p_ds;
  logic signed [SUM_W-1:0]  ox_ext;
  logic signed [SUM_W-1:0]  oy_ext;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;
  logic [SUM_W-1:0]         abs_x;
  logic [SUM_W-1:0]         abs_y;
  logic                     va;
  logic                     vb;
  logic                     vc;

  assign off_ext   = LAT_W'(column_offset);
  assign row_ext   = LAT_W'(screen_row);
  assign lstep_ext = LAT_W'($signed({1'b0, lateral_step}));
  assign dstep_ext = LAT_W'($signed({1'b0, depth_step}));
  assign lat_ext   = PROD_W'(lat);
  assign dep_ext   = PROD_W'(dep);
  assign cos_ext   = PROD_W'(cos_angle);
  assign sin_ext   = PROD_W'(sin_angle);
  assign ox_ext    = SUM_W'(origin_x) <<< pfta_pkg::TRIG_FRAC;
  assign oy_ext    = SUM_W'(origin_y) <<< pfta_pkg::TRIG_FRAC;
  assign abs_x     = sum_x[SUM_W-1] ? (~sum_x + 1'b1) : sum_x;
  assign abs_y     = sum_y[SUM_W-1] ? (~sum_y + 1'b1) : sum_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      vc    <= 1'b0;
      valid <= 1'b0;
    end else if (ctrl.adv) begin
      va    <= ctrl.valid;
      vb    <= va;
      vc    <= vb;
      valid <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      lat   <= off_ext * lstep_ext;
      dep   <= row_ext * dstep_ext;
      p_lc  <= lat_ext * cos_ext;
      p_ls  <= lat_ext * sin_ext;
      p_dc  <= dep_ext * cos_ext;
      p_ds  <= dep_ext * sin_ext;
      sum_x <= ox_ext + SUM_W'(p_lc) - SUM_W'(p_ds);
      sum_y <= oy_ext + SUM_W'(p_ls) + SUM_W'(p_dc);
      x_neg <= sum_x[SUM_W-1];
      y_neg <= sum_y[SUM_W-1];
      x_mag <= abs_x[SHIFT +: MAG_W];
      y_mag <= abs_y[SHIFT +: MAG_W];
    end
  end

endmodule

/* rtl/pfta_wrap.sv */
// Pipelined remainder of a magnitude by the texture size, four bits per
// stage, then the fix to a non-negative result. Depends on pfta_pkg.

module pfta_wrap #(
  parameter int MAG_W = pfta_pkg::mag_width(pfta_pkg::COORD_BITS_DEF,
                                            pfta_pkg::FRAC_BITS_DEF)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pfta_pkg::pipe_ctrl_t           ctrl,
  input  logic                           neg,
  input  logic [MAG_W-1:0]               mag,
  input  logic [pfta_pkg::DIM_W-1:0]     dim,
  output logic                           valid,
  output logic [pfta_pkg::TEX_W-1:0]     coord
);

  localparam int DIGIT = pfta_pkg::DIGIT;
  localparam int DIM_W = pfta_pkg::DIM_W;
  localparam int NSTEP = (MAG_W + DIGIT - 1) / DIGIT;
  localparam int PAD_W = NSTEP * DIGIT;

  logic [NSTEP-1:0] v;
  logic [NSTEP-1:0] sgn;
  logic [DIM_W-1:0] rem  [NSTEP];
  logic [PAD_W-1:0] bits [NSTEP];
  logic [DIM_W-1:0] rem_last;
  logic             neg_last;

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic [DIM_W-1:0] r_in;
    logic [PAD_W-1:0] b_in;
    logic             n_in;
    logic             v_in;
    logic [DIM_W:0]   trial [DIGIT];
    logic [DIM_W-1:0] r_chain [DIGIT+1];

    if (i == 0) begin : g_head
      assign r_in = '0;
      assign b_in = PAD_W'(mag);
      assign n_in = neg;
      assign v_in = ctrl.valid;
    end else begin : g_body
      assign r_in = rem[i-1];
      assign b_in = bits[i-1];
      assign n_in = sgn[i-1];
      assign v_in = v[i-1];
    end

    always_comb begin
      r_chain[0] = r_in;
      for (int k = 0; k < DIGIT; k++) begin
        trial[k] = {r_chain[k], b_in[PAD_W-1-k]};
        if (trial[k] >= {1'b0, dim}) begin
          trial[k] = trial[k] - {1'b0, dim};
        end
        r_chain[k+1] = trial[k][DIM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (ctrl.adv) begin
        v[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctrl.adv) begin
        rem[i]  <= r_chain[DIGIT];
        bits[i] <= b_in << DIGIT;
        sgn[i]  <= n_in;
      end
    end
  end

  assign rem_last = rem[NSTEP-1];
  assign neg_last = sgn[NSTEP-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.adv) begin
      valid <= v[NSTEP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      if (neg_last && (rem_last != '0)) begin
        coord <= pfta_pkg::TEX_W'(dim - rem_last);
      end else begin
        coord <= pfta_pkg::TEX_W'(rem_last);
      end
    end
  end

endmodule

/* rtl/pfta_index.sv */
// Linear texel index: row times width, then add the column into the output
// register. Depends on pfta_pkg.

module pfta_index (
  input  logic                           clk,
  input  logic                           rst,
  input  pfta_pkg::pipe_ctrl_t           ctrl,
  input  logic [pfta_pkg::TEX_W-1:0]     tx,
  input  logic [pfta_pkg::TEX_W-1:0]     ty,
  input  logic [pfta_pkg::DIM_W-1:0]     width,
  output logic                           valid,
  output logic [pfta_pkg::TEX_W-1:0]     texel_x,
  output logic [pfta_pkg::TEX_W-1:0]     texel_y,
  output logic [pfta_pkg::INDEX_W-1:0]   texel_index
);

  localparam int PROD_W = pfta_pkg::TEX_W + pfta_pkg::DIM_W;

  logic                          v1;
  logic [pfta_pkg::TEX_W-1:0]    tx1;
  logic [pfta_pkg::TEX_W-1:0]    ty1;
  logic [PROD_W-1:0]             prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      valid <= 1'b0;
    end else if (ctrl.adv) begin
      v1    <= ctrl.valid;
      valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      tx1         <= tx;
      ty1         <= ty;
      prod        <= PROD_W'(ty) * PROD_W'(width);
      texel_x     <= tx1;
      texel_y     <= ty1;
      texel_index <= pfta_pkg::INDEX_W'(tx1) + prod[pfta_pkg::INDEX_W-1:0];
    end
  end

endmodule

/* rtl/perspective_floor_texel_address.sv */
// Top level of the floor texel address pipeline: configuration registers,
// stall control, and the rotate, wrap and index stages. Depends on pfta_pkg,
// pfta_if, pfta_rotate, pfta_wrap and pfta_index.
//
//   channel  direction  handshake      payload
//   pixel    in         valid/ready    column_offset, screen_row
//   texel    out        valid/ready    texel_x, texel_y, texel_index
//   wr_*     in         wr_en only     wr_index, wr_data
//
// One beat per cycle in and out while the output is not stalled; beats pass
// through rotate, the digit-per-stage remainder pipelines and index in order.
// Reset clears all valid bits; configuration returns to its reset values.
// The whole pipeline holds when the output register is full and not taken.

module perspective_floor_texel_address #(
  parameter int COORD_BITS = pfta_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = pfta_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [pfta_pkg::CFG_INDEX_W-1:0]    wr_index,
  input  logic [pfta_pkg::CFG_DATA_W-1:0]     wr_data,
  pfta_in_if.sink                             pixel,
  pfta_out_if.source                          texel
);

  localparam int MAG_W = pfta_pkg::mag_width(COORD_BITS, FRAC_BITS);

  logic signed [pfta_pkg::STEP_W-1:0] origin_x;
  logic signed [pfta_pkg::STEP_W-1:0] origin_y;
  logic signed [pfta_pkg::TRIG_W-1:0] cos_angle;
  logic signed [pfta_pkg::TRIG_W-1:0] sin_angle;
  logic [pfta_pkg::STEP_W-1:0]        depth_step;
  logic [pfta_pkg::STEP_W-1:0]        lateral_step;
  logic [pfta_pkg::DIM_W-1:0]         texture_width;
  logic [pfta_pkg::DIM_W-1:0]         texture_height;

  logic signed [pfta_pkg::TRIG_W-1:0] trig_wr;
  logic signed [pfta_pkg::TRIG_W-1:0] trig_next;
  logic [pfta_pkg::DIM_W-1:0]         dim_wr;
  logic [pfta_pkg::DIM_W-1:0]         dim_next;

  logic                               adv;
  logic                               rot_valid;
  logic                               x_neg;
  logic                               y_neg;
  logic [MAG_W-1:0]                   x_mag;
  logic [MAG_W-1:0]                   y_mag;
  logic                               wx_valid;
  logic                               wy_valid;
  logic [pfta_pkg::TEX_W-1:0]         tx;
  logic [pfta_pkg::TEX_W-1:0]         ty;

  assign trig_wr = wr_data[pfta_pkg::TRIG_W-1:0];
  assign dim_wr  = wr_data[pfta_pkg::DIM_W-1:0];

  always_comb begin
    if (trig_wr > pfta_pkg::TRIG_POS) begin
      trig_next = pfta_pkg::TRIG_POS;
    end else if (trig_wr < pfta_pkg::TRIG_NEG) begin
      trig_next = pfta_pkg::TRIG_NEG;
    end else begin
      trig_next = trig_wr;
    end
    if (dim_wr == '0) begin
      dim_next = pfta_pkg::TEX_MIN;
    end else if (dim_wr > pfta_pkg::TEX_MAX) begin
      dim_next = pfta_pkg::TEX_MAX;
    end else begin
      dim_next = dim_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      cos_angle      <= pfta_pkg::COS_RESET;
      sin_angle      <= '0;
      depth_step     <= pfta_pkg::DEPTH_RESET;
      lateral_step   <= pfta_pkg::LATERAL_RESET;
      texture_width  <= pfta_pkg::DIM_RESET;
      texture_height <= pfta_pkg::DIM_RESET;
    end else if (wr_en) begin
      case (wr_index)
        pfta_pkg::REG_ORIGIN_X:       origin_x       <= wr_data;
        pfta_pkg::REG_ORIGIN_Y:       origin_y       <= wr_data;
        pfta_pkg::REG_COS_ANGLE:      cos_angle      <= trig_next;
        pfta_pkg::REG_SIN_ANGLE:      sin_angle      <= trig_next;
        pfta_pkg::REG_DEPTH_STEP:     depth_step     <= wr_data;
        pfta_pkg::REG_LATERAL_STEP:   lateral_step   <= wr_data;
        pfta_pkg::REG_TEXTURE_WIDTH:  texture_width  <= dim_next;
        pfta_pkg::REG_TEXTURE_HEIGHT: texture_height <= dim_next;
        default: ;
      endcase
    end
  end

  assign adv         = !texel.valid || texel.ready;
  assign pixel.ready = adv;

  pfta_rotate #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rotate (
    .clk           (clk),
    .rst           (rst),
    .ctrl          ('{adv: adv, valid: pixel.valid}),
    .column_offset (pixel.column_offset),
    .screen_row    (pixel.screen_row),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .cos_angle     (cos_angle),
    .sin_angle     (sin_angle),
    .depth_step    (depth_step),
    .lateral_step  (lateral_step),
    .valid         (rot_valid),
    .x_neg         (x_neg),
    .x_mag         (x_mag),
    .y_neg         (y_neg),
    .y_mag         (y_mag)
  );

  pfta_wrap #(
    .MAG_W (MAG_W)
  ) u_wrap_x (
    .clk   (clk),
    .rst   (rst),
    .ctrl  ('{adv: adv, valid: rot_valid}),
    .neg   (x_neg),
    .mag   (x_mag),
    .dim   (texture_width),
    .valid (wx_valid),
    .coord (tx)
  );

  pfta_wrap #(
    .MAG_W (MAG_W)
  ) u_wrap_y (
    .clk   (clk),
    .rst   (rst),
    .ctrl  ('{adv: adv, valid: rot_valid}),
    .neg   (y_neg),
    .mag   (y_mag),
    .dim   (texture_height),
    .valid (wy_valid),
    .coord (ty)
  );

  pfta_index u_index (
    .clk         (clk),
    .rst         (rst),
    .ctrl        ('{adv: adv, valid: wx_valid && wy_valid}),
    .tx          (tx),
    .ty          (ty),
    .width       (texture_width),
    .valid       (texel.valid),
    .texel_x     (texel.texel_x),
    .texel_y     (texel.texel_y),
    .texel_index (texel.texel_index)
  );

endmodule

/* rtl/pfta_checker.sv */
// Port-level checks for the floor texel address pipeline, bound to the top
// level. Depends on pfta_pkg and perspective_floor_texel_address.

module pfta_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [pfta_pkg::TEX_W-1:0]     texel_x,
  input logic [pfta_pkg::TEX_W-1:0]     texel_y,
  input logic [pfta_pkg::INDEX_W-1:0]   texel_index
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_no_block: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while output can move");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(texel_x) && $stable(texel_y) && $stable(texel_index)))
    else $error("stalled output beat changed");

  a_index_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (texel_index >= pfta_pkg::INDEX_W'(texel_x)))
    else $error("texel index below texel x");

  a_index_row0: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((texel_y == '0) == (texel_index == pfta_pkg::INDEX_W'(texel_x))))
    else $error("texel index disagrees with texel row");

endmodule

bind perspective_floor_texel_address pfta_checker u_pfta_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (pixel.ready),
  .out_valid   (texel.valid),
  .out_ready   (texel.ready),
  .texel_x     (texel.texel_x),
  .texel_y     (texel.texel_y),
  .texel_index (texel.texel_index)
);
